FILE: rtl/log_average_luminance_assert.svh
// assertion macros for the log-average luminance block
// expects aclk and aresetn in the scope of each use
`ifndef LOG_AVERAGE_LUMINANCE_ASSERT_SVH
`define LOG_AVERAGE_LUMINANCE_ASSERT_SVH

// same-cycle implication
`define LAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lal_pkg.sv
// shared types, constants and table builders for the log-average luminance block
// no dependencies
`default_nettype none

package lal_pkg;

    localparam int MAX_PIXELS_DEF     = 4194304;
    localparam int LOG_TABLE_BITS_DEF = 8;

    localparam int CH_W   = 16;
    localparam int PROD_W = 32;
    localparam int LUM_W  = 34;
    localparam int POS_W  = 6;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = 22;
    localparam int SUM_W  = 48;
    localparam int EXP_STEPS = 16;
    localparam int EXP_W  = 32;

    localparam logic [CH_W-1:0] W_RED   = 16'd13933;
    localparam logic [CH_W-1:0] W_GREEN = 16'd46871;
    localparam logic [CH_W-1:0] W_BLUE  = 16'd4732;
    localparam int LUM_FRAC = 24;

    localparam logic signed [LOG_W-1:0] LOG_FLOOR = -22'sd1088529;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic signed [LOG_W-1:0] log_val;
        logic                    last;
    } lal_item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } lal_fifo_stat_t;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + idx / 2^t) in Q0.16 by repeated squaring of a Q1.30 mantissa
    function automatic logic [FRAC_W-1:0] log_entry(input int idx, input int t);
        logic [63:0]       m;
        logic [FRAC_W-1:0] res;
        m   = (64'd1 << 30) + (64'(idx) << (30 - t));
        res = '0;
        for (int k = 1; k <= 16; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                res[16-k] = 1'b1;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30
    function automatic logic [EXP_W-1:0] exp_const(input int k);
        logic [63:0] c;
        c = floor_sqrt(64'd2 << 60);
        for (int j = 1; j < 16; j++) begin
            if (j < k) begin
                c = floor_sqrt(c << 30);
            end
        end
        return c[EXP_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/log_average_luminance.sv
// channel   dir  signals                                         width
// pixel     in   s_valid s_ready s_red s_green s_blue s_last_pixel 16/16/16/1
// result    out  m_valid m_ready m_average_luminance               16
//
// front takes one pixel a clock, unless the full queue stalls it, through a three-stage luminance/log2 pipe
// back adds one log per clock while accumulating and is busy after a last pixel with:
// one load, 48 restoring divide steps, one mean step, 16 exp2 product steps unless the mean saturates
// a four-entry queue absorbs pixels while the back works, then s_ready drops
// synchronous active-low reset clears sum, count, queue and pipe valid bits
// depends on lal_pkg, lal_front, lal_fifo, lal_back, log_average_luminance_assert.svh
`default_nettype none

`include "log_average_luminance_assert.svh"

module log_average_luminance
    import lal_pkg::*;
#(
    parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [CH_W-1:0]  s_red,
    input  wire logic [CH_W-1:0]  s_green,
    input  wire logic [CH_W-1:0]  s_blue,
    input  wire logic             s_last_pixel,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [CH_W-1:0]       m_average_luminance
);

    lal_item_t      push_item, rd_item;
    logic           push_valid, push_ready;
    logic           rd_valid, rd_ready;
    lal_fifo_stat_t fifo_stat;

    lal_front #(
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_last_pixel (s_last_pixel),
        .push_item    (push_item),
        .push_valid   (push_valid),
        .push_ready   (push_ready)
    );

    lal_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_item  (push_item),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .rd_item  (rd_item),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .stat     (fifo_stat)
    );

    lal_back #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .rd_item             (rd_item),
        .rd_valid            (rd_valid),
        .rd_ready            (rd_ready),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_average_luminance (m_average_luminance)
    );

    `LAL_ASSERT_NEXT(a_one_result, m_valid && m_ready, !m_valid, "result repeated")
    `LAL_ASSERT_NEXT(a_q_push, push_valid && push_ready && !(rd_valid && rd_ready), fifo_stat.count == $past(fifo_stat.count) + 1'b1, "queue count lost a push")
    `LAL_ASSERT_IMP(a_q_bound, fifo_stat.full, !push_ready && rd_valid, "queue overfilled")

endmodule

`default_nettype wire

FILE: rtl/lal_front.sv
// front end: luminance, leading-one detect and log2 table per pixel
// depends on lal_pkg
`default_nettype none

module lal_front
    import lal_pkg::*;
#(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CH_W-1:0]   s_red,
    input  wire logic [CH_W-1:0]   s_green,
    input  wire logic [CH_W-1:0]   s_blue,
    input  wire logic              s_last_pixel,
    output lal_item_t              push_item,
    output logic                   push_valid,
    input  wire logic              push_ready
);

    localparam int TAB_N = 1 << LOG_TABLE_BITS;

    logic [FRAC_W-1:0] log_tab [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
        assign log_tab[gi] = log_entry(gi, LOG_TABLE_BITS);
    end

    logic              advance;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [PROD_W-1:0] s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic              s1_last_reg, s2_last_reg;
    logic [LUM_W-1:0]  s2_lum_reg;
    logic [POS_W-1:0]  s2_pos_reg;
    logic              s2_zero_reg;
    lal_item_t         s3_item_reg;

    logic [LUM_W-1:0]  lum;
    logic [POS_W-1:0]  pos;
    logic [LUM_W-1:0]  norm;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [POS_W-1:0]  int_part;
    logic [LOG_W-1:0]  log_raw;
    lal_item_t         s3_item_next;

    assign advance = !s3_valid_reg || push_ready;
    assign s_ready = advance;

    always_comb begin
        lum = {2'b00, s1_pr_reg} + {2'b00, s1_pg_reg} + {2'b00, s1_pb_reg};
        pos = '0;
        for (int i = 0; i < LUM_W; i++) begin
            if (lum[i]) begin
                pos = POS_W'(i);
            end
        end
    end

    always_comb begin
        // bring the leading one to the top, table index sits right below it
        norm     = s2_lum_reg << (POS_W'(LUM_W - 1) - s2_pos_reg);
        idx      = norm[LUM_W-2 -: LOG_TABLE_BITS];
        int_part = s2_pos_reg - POS_W'(LUM_FRAC);
        log_raw  = {int_part, log_tab[idx]};
        s3_item_next.last = s2_last_reg;
        if (s2_zero_reg || ($signed(log_raw) < LOG_FLOOR)) begin
            s3_item_next.log_val = LOG_FLOOR;
        end else begin
            s3_item_next.log_val = $signed(log_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pr_reg   <= PROD_W'(s_red * W_RED);
            s1_pg_reg   <= PROD_W'(s_green * W_GREEN);
            s1_pb_reg   <= PROD_W'(s_blue * W_BLUE);
            s1_last_reg <= s_last_pixel;
            s2_lum_reg  <= lum;
            s2_pos_reg  <= pos;
            s2_zero_reg <= (lum == '0);
            s2_last_reg <= s1_last_reg;
            s3_item_reg <= s3_item_next;
        end
    end

    assign push_item  = s3_item_reg;
    assign push_valid = s3_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/lal_fifo.sv
// small request queue between front and back
// depends on lal_pkg
`default_nettype none

module lal_fifo
    import lal_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire lal_item_t  wr_item,
    input  wire logic       wr_valid,
    output logic            wr_ready,
    output lal_item_t       rd_item,
    output logic            rd_valid,
    input  wire logic       rd_ready,
    output lal_fifo_stat_t  stat
);

    lal_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               push, pop;

    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    assign wr_ready = !stat.full;
    assign rd_valid = !stat.empty;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lal_back.sv
// back end: log sum and pixel count, serial divide, exp2 by constant products
// depends on lal_pkg
`default_nettype none

module lal_back
    import lal_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire lal_item_t   rd_item,
    input  wire logic        rd_valid,
    output logic             rd_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [CH_W-1:0]  m_average_luminance
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int K_W    = $clog2(EXP_STEPS);
    localparam int MW     = SUM_W + 1;

    typedef enum logic [5:0] {
        ST_ACC  = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MEAN = 6'b001000,
        ST_EXP  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    logic [EXP_W-1:0] exp_tab [EXP_STEPS];

    for (genvar gi = 0; gi < EXP_STEPS; gi++) begin : g_exp
        assign exp_tab[gi] = exp_const(gi + 1);
    end

    state_t                  state_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W:0]          rem_reg;
    logic [CNT_W-1:0]        div_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    sat_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [POS_W-1:0]        sh_reg;
    logic [EXP_W-1:0]        r_reg;
    logic [K_W-1:0]          k_reg;

    logic [CNT_W:0]          rem_shift;
    logic                    q_bit;
    logic [MW-1:0]           q_adj;
    logic signed [MW-1:0]    mean;
    logic signed [MW-1:0]    mean_clamped;
    logic [MW-1:0]           u_full;
    logic [63:0]             prod;
    logic [EXP_W-1:0]        shifted;

    assign rd_ready = (state_reg == ST_ACC);
    assign m_valid  = (state_reg == ST_OUT);

    always_comb begin
        rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, div_reg});
    end

    always_comb begin
        // floor division: round the magnitude up when the sum was negative
        q_adj = {1'b0, quo_reg} + MW'(neg_reg && (rem_reg != '0));
        mean  = neg_reg ? -$signed(q_adj) : $signed(q_adj);
        if (mean < -$signed(MW'(32 << FRAC_W))) begin
            mean_clamped = -$signed(MW'(32 << FRAC_W));
        end else begin
            mean_clamped = mean;
        end
        u_full = MW'(mean_clamped) + MW'(32 << FRAC_W);
    end

    assign prod    = 64'(r_reg) * 64'(exp_tab[k_reg]);
    assign shifted = r_reg >> sh_reg;

    always_comb begin
        if (sat_reg || (shifted[EXP_W-1:CH_W] != '0)) begin
            m_average_luminance = '1;
        end else begin
            m_average_luminance = shifted[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_ACC: begin
                    if (rd_valid) begin
                        if (cnt_reg < CNT_W'(MAX_PIXELS)) begin
                            sum_reg <= sum_reg + SUM_W'(rd_item.log_val);
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (rd_item.last) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == STEP_W'(SUM_W - 1)) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    state_reg <= (mean >= $signed(MW'(8 << FRAC_W))) ? ST_OUT : ST_EXP;
                end
                ST_EXP: begin
                    if (k_reg == K_W'(EXP_STEPS - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_ACC;
                    end
                end
                default: state_reg <= ST_ACC;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LOAD: begin
                neg_reg  <= sum_reg[SUM_W-1];
                quo_reg  <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                div_reg  <= (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= q_bit ? (rem_shift - {1'b0, div_reg}) : rem_shift;
                quo_reg  <= {quo_reg[SUM_W-2:0], q_bit};
                step_reg <= step_reg + 1'b1;
            end
            ST_MEAN: begin
                sat_reg  <= (mean >= $signed(MW'(8 << FRAC_W)));
                frac_reg <= u_full[FRAC_W-1:0];
                sh_reg   <= POS_W'(54) - u_full[FRAC_W +: POS_W];
                r_reg    <= EXP_W'(1) << 30;
                k_reg    <= '0;
            end
            ST_EXP: begin
                if (frac_reg[K_W'(EXP_STEPS - 1) - k_reg]) begin
                    r_reg <= prod[61:30];
                end
                k_reg <= k_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
